// ===== sv/bap_pkg.sv =====
// Shared types and fixed widths for the block-average pixelate core.
// No dependencies.
package bap_pkg;

    localparam int SUM_W   = 20;
    localparam int CH_W    = 8;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 11;
    localparam int SPAN_W  = 7;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 2;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 72;
    localparam int QBITS   = 8;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_BLOCK  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RMW  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef logic [SUM_W-1:0] sum_t;

endpackage

// ===== sv/block_average_pixelate_core.sv =====
// Block-average pixelate core: per-block-column channel sums in one RAM, iterative mean.
// Depends on bap_pkg.
//
//  channel | dir | fields (low bit up)
//  s_axis  | in  | tdata: alpha_in, red_in, green_in, blue_in
//  m_axis  | out | tdata: block_col, block_row, span_width, span_height,
//          |     |        avg_alpha, avg_red, avg_green, avg_blue; tlast: frame_done
//  cfg     | in  | we, index, data (image_width, image_height, block_size)
//
// A pixel that does not end a block passes through accept and the RAM read-modify-write.
// A block-ending pixel passes through accept, read-modify-write, 8 restoring divide steps
// that produce one quotient bit per cycle, and the load of the output register.
// The output register holds a result while m_tready is low; the core then waits
// in its load step. Reset clears control only; the sum RAM needs no clearing pass.
module block_average_pixelate_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_BLOCK  = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // alpha_in[7:0], red_in[15:8], green_in[23:16], blue_in[31:24]
    input  logic [bap_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // block_col[10:0], block_row[21:11], span_width[28:22], span_height[35:29],
    // avg_alpha[43:36], avg_red[51:44], avg_green[59:52], avg_blue[67:60], zeros
    output logic [bap_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic [bap_pkg::IDX_W-1:0]   cfg_index,
    input  logic [bap_pkg::CFG_W-1:0]   cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int AH = $clog2(MAX_HEIGHT);
    localparam int WW = AW + 1;
    localparam int HW = AH + 1;
    localparam int CB = $clog2(MAX_BLOCK);
    localparam int BW = CB + 1;
    localparam int NW = 2 * BW;
    localparam int DW = bap_pkg::SUM_W + NW + bap_pkg::QBITS;
    localparam int MW = 4 * bap_pkg::SUM_W;

    logic [bap_pkg::CFG_W-1:0] cfg_w_reg, cfg_h_reg;
    logic [6:0]                cfg_b_reg;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [BW-1:0] b_eff;

    logic [AW-1:0] pcol_reg;
    logic [AH-1:0] prow_reg, brow_reg;
    logic [CB-1:0] cib_reg, rib_reg;
    logic [AW-1:0] bidx_reg;

    bap_pkg::state_t state_reg;
    logic [2:0]      step_reg;

    logic [MW-1:0] mem [MAX_WIDTH];
    logic [MW-1:0] rdata_reg;

    logic [AW-1:0] idx_reg;
    logic [AH-1:0] obrow_reg;
    logic [BW-1:0] sw_reg, sh_reg;
    logic          fresh_reg, bend_reg, fdone_reg;
    logic [bap_pkg::IN_W-1:0] pix_reg;
    bap_pkg::sum_t rem_reg [4];
    logic [bap_pkg::QBITS-1:0] q_reg [4];
    logic [NW-1:0] cnt_reg;

    logic m_valid_reg, m_last_reg;
    logic [bap_pkg::OUT_W-1:0] m_data_reg;

    logic accept, fresh, col_end, row_end, line_end, last_row;
    bap_pkg::sum_t new_sum [4];
    logic [MW-1:0] wdata;
    logic [DW-1:0] dsh;

    always_comb
    begin
        if (cfg_w_reg == '0)
            w_eff = WW'(1);
        else if (32'(cfg_w_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(cfg_w_reg);
        if (cfg_h_reg == '0)
            h_eff = HW'(1);
        else if (32'(cfg_h_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(cfg_h_reg);
        if (cfg_b_reg == '0)
            b_eff = BW'(1);
        else if (32'(cfg_b_reg) > 32'(MAX_BLOCK))
            b_eff = BW'(MAX_BLOCK);
        else
            b_eff = BW'(cfg_b_reg);
    end

    assign s_tready = (state_reg == bap_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign fresh    = (cib_reg == '0) && (rib_reg == '0);
    assign line_end = ({1'b0, pcol_reg} + WW'(1)) >= w_eff;
    assign last_row = ({1'b0, prow_reg} + HW'(1)) >= h_eff;
    assign col_end  = (({1'b0, cib_reg} + BW'(1)) >= b_eff) || line_end;
    assign row_end  = (({1'b0, rib_reg} + BW'(1)) >= b_eff) || last_row;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            new_sum[c] = (fresh_reg ? '0 : rdata_reg[c*bap_pkg::SUM_W +: bap_pkg::SUM_W])
                       + bap_pkg::SUM_W'(pix_reg[c*bap_pkg::CH_W +: bap_pkg::CH_W]);
            wdata[c*bap_pkg::SUM_W +: bap_pkg::SUM_W] = new_sum[c];
        end
    end

    assign dsh = DW'(cnt_reg) << step_reg;

    // Sum RAM: read on accept, write back in the following cycle
    always_ff @(posedge clk)
    begin
        if (accept)
            rdata_reg <= mem[bidx_reg];
        if (state_reg == bap_pkg::ST_RMW)
            mem[idx_reg] <= wdata;
    end

    // Payload captured per item and divider datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg   <= s_tdata;
            idx_reg   <= bidx_reg;
            obrow_reg <= brow_reg;
            sw_reg    <= {1'b0, cib_reg} + BW'(1);
            sh_reg    <= {1'b0, rib_reg} + BW'(1);
            fresh_reg <= fresh;
            bend_reg  <= col_end && row_end;
            fdone_reg <= line_end && last_row;
        end
        if (state_reg == bap_pkg::ST_RMW)
        begin
            cnt_reg <= sw_reg * sh_reg;
            for (int c = 0; c < 4; c++)
                rem_reg[c] <= new_sum[c];
        end
        if (state_reg == bap_pkg::ST_DIV)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (DW'(rem_reg[c]) >= dsh)
                begin
                    rem_reg[c]        <= bap_pkg::SUM_W'(DW'(rem_reg[c]) - dsh);
                    q_reg[c][step_reg] <= 1'b1;
                end
                else
                    q_reg[c][step_reg] <= 1'b0;
            end
        end
        if (state_reg == bap_pkg::ST_DONE && (!m_valid_reg || m_tready))
        begin
            m_data_reg <= {4'b0, q_reg[3], q_reg[2], q_reg[1], q_reg[0],
                           bap_pkg::SPAN_W'(sh_reg), bap_pkg::SPAN_W'(sw_reg),
                           bap_pkg::ROW_W'(obrow_reg), bap_pkg::COL_W'(idx_reg)};
            m_last_reg <= fdone_reg;
        end
    end

    // Control: config, position counters, sequencer, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg   <= bap_pkg::CFG_W'(640);
            cfg_h_reg   <= bap_pkg::CFG_W'(480);
            cfg_b_reg   <= 7'd8;
            pcol_reg    <= '0;
            prow_reg    <= '0;
            brow_reg    <= '0;
            cib_reg     <= '0;
            rib_reg     <= '0;
            bidx_reg    <= '0;
            state_reg   <= bap_pkg::ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index inside {bap_pkg::REG_WIDTH, bap_pkg::REG_HEIGHT,
                                             bap_pkg::REG_BLOCK}))
            begin
                case (cfg_index)
                    bap_pkg::REG_WIDTH:  cfg_w_reg <= cfg_data;
                    bap_pkg::REG_HEIGHT: cfg_h_reg <= cfg_data;
                    bap_pkg::REG_BLOCK:  cfg_b_reg <= cfg_data[6:0];
                    default:             cfg_b_reg <= cfg_b_reg;
                endcase
                // restart the frame
                pcol_reg <= '0;
                prow_reg <= '0;
                brow_reg <= '0;
                cib_reg  <= '0;
                rib_reg  <= '0;
                bidx_reg <= '0;
            end
            else if (accept)
            begin
                if (line_end)
                begin
                    pcol_reg <= '0;
                    cib_reg  <= '0;
                    bidx_reg <= '0;
                    if (last_row)
                    begin
                        prow_reg <= '0;
                        rib_reg  <= '0;
                        brow_reg <= '0;
                    end
                    else
                    begin
                        prow_reg <= prow_reg + AH'(1);
                        rib_reg  <= row_end ? '0 : rib_reg + CB'(1);
                        if (row_end)
                            brow_reg <= brow_reg + AH'(1);
                    end
                end
                else
                begin
                    pcol_reg <= pcol_reg + AW'(1);
                    if (col_end)
                    begin
                        cib_reg  <= '0;
                        bidx_reg <= bidx_reg + AW'(1);
                    end
                    else
                        cib_reg <= cib_reg + CB'(1);
                end
            end

            // load a new result, or drop the one just taken
            if (state_reg == bap_pkg::ST_DONE && (!m_valid_reg || m_tready))
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;

            case (state_reg)
                bap_pkg::ST_IDLE:
                    if (accept)
                        state_reg <= bap_pkg::ST_RMW;
                bap_pkg::ST_RMW:
                begin
                    step_reg  <= 3'd7;
                    state_reg <= bend_reg ? bap_pkg::ST_DIV : bap_pkg::ST_IDLE;
                end
                bap_pkg::ST_DIV:
                begin
                    step_reg <= step_reg - 3'd1;
                    if (step_reg == 3'd0)
                        state_reg <= bap_pkg::ST_DONE;
                end
                bap_pkg::ST_DONE:
                    if (!m_valid_reg || m_tready)
                        state_reg <= bap_pkg::ST_IDLE;
                default:
                    state_reg <= bap_pkg::ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== sv/bap_checker.sv =====
// Port-level checks for the block-average pixelate core, bound to the top level.
// Depends on bap_pkg and block_average_pixelate_core.
module bap_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [bap_pkg::OUT_W-1:0] m_tdata,
    input logic                      m_tlast
);

    // one item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in flight");

    // a result never appears in the cycle after an accept
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared too soon after an item");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind block_average_pixelate_core bap_checker u_bap_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
